@@ design/rotation_matrix_to_euler_macros.svh @@
// ----------------------------------------------------------------------------
// rotation matrix to euler macros
// assertion helpers used by the top design file
// ----------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_EULER_MACROS_SVH
`define ROTATION_MATRIX_TO_EULER_MACROS_SVH

// same-cycle implication
`define RME_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rme: same-cycle property failed");

// next-cycle implication
`define RME_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rme: next-cycle property failed");

`endif

@@ design/rme_pkg.sv @@
// ----------------------------------------------------------------------------
// rme package
// shared types and constants of the rotation matrix to euler block
// ----------------------------------------------------------------------------
package rme_pkg;

  localparam int TAB_LEN = 24;
  localparam int SQRT_STAGES = 17;
  localparam logic [15:0] THRESHOLD_RESET = 16'd328;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic signed [31:0] TWO_PI_Q16 = 32'sd411775;
  localparam logic [29:0] DEG_PER_RAD_Q24 = 30'd961263669;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  localparam logic [31:0] ATAN_Q30 [TAB_LEN] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
    32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
    32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
    32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  typedef struct packed {
    logic signed [17:0] r0c0;
    logic signed [17:0] r0c1;
    logic signed [17:0] r1c0;
    logic signed [17:0] r1c1;
    logic signed [17:0] r1c2;
    logic signed [17:0] r2c2;
    logic signed [17:0] s;
    logic [1:0]         sel;
  } side_t;

  typedef struct packed {
    side_t       side;
    logic [32:0] sq;
  } word_t;

endpackage

@@ design/rme_if.sv @@
// ----------------------------------------------------------------------------
// rme channel interfaces
// matrix word in, euler angle word out, valid/ready handshake
// ----------------------------------------------------------------------------
interface rme_item_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] r0c0;
  logic signed [17:0] r0c1;
  logic signed [17:0] r0c2;
  logic signed [17:0] r1c0;
  logic signed [17:0] r1c1;
  logic signed [17:0] r1c2;
  logic signed [17:0] r2c2;
  logic [1:0]         axis_sel;

  modport source (output valid, r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c2, axis_sel,
                  input ready);
  modport sink (input valid, r0c0, r0c1, r0c2, r1c0, r1c1, r1c2, r2c2, axis_sel,
                output ready);
endinterface

interface rme_result_if;
  logic        valid;
  logic        ready;
  logic [18:0] angle_x;
  logic [18:0] angle_y;
  logic [18:0] angle_z;
  logic [16:0] selected_degrees;
  logic        gimbal_lock;

  modport source (output valid, angle_x, angle_y, angle_z, selected_degrees, gimbal_lock,
                  input ready);
  modport sink (input valid, angle_x, angle_y, angle_z, selected_degrees, gimbal_lock,
                output ready);
endinterface

@@ design/rotation_matrix_to_euler.sv @@
// ----------------------------------------------------------------------------
// rotation matrix to euler
// x-y-z euler angles from a rotation matrix, while results are taken one word per cycle
// ----------------------------------------------------------------------------
//  channel   direction  handshake      payload
//  item      in         valid/ready    r0c0..r2c2, axis_sel
//  result    out        valid/ready    angle_x/y/z, selected_degrees, gimbal_lock
//  cfg       in         cfg_wr_en      gimbal_threshold (16 bits)
//
//  one word per cycle sustained while results are taken; words pass through the
//  front register, queue slot, 17-stage square root, cordic entry, iteration
//  and wrap stages, and two output registers
//  rst is synchronous and clears valid state; threshold resets to 328
//  a stalled result freezes the back pipeline; until its two entries fill, the
//  queue keeps the front taking words meanwhile
// ----------------------------------------------------------------------------
`include "rotation_matrix_to_euler_macros.svh"

module rotation_matrix_to_euler #(
  parameter int CORDIC_STEPS = 16,
  parameter int FRAC_BITS    = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_wr_en,
  input  logic [15:0]   cfg_wr_data,
  rme_item_if.sink      item,
  rme_result_if.source  result
);

  logic [15:0]    gimbal_threshold;
  logic           f_valid;
  logic           f_ready;
  rme_pkg::word_t f_word;
  logic           q_valid;
  logic           q_ready;
  rme_pkg::word_t q_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      gimbal_threshold <= rme_pkg::THRESHOLD_RESET;
    end else if (cfg_wr_en) begin
      gimbal_threshold <= cfg_wr_data;
    end
  end

  rme_front u_front (
    .clk(clk), .rst(rst), .item(item),
    .word_valid(f_valid), .word_ready(f_ready), .word(f_word)
  );

  rme_queue u_queue (
    .clk(clk), .rst(rst),
    .push_valid(f_valid), .push_ready(f_ready), .push_word(f_word),
    .pop_valid(q_valid), .pop_ready(q_ready), .pop_word(q_word)
  );

  rme_back #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .threshold(gimbal_threshold),
    .word_valid(q_valid), .word_ready(q_ready), .word(q_word), .result(result)
  );

  `RME_ASSERT_IMPLY(a_lock_zeroes_x, clk, rst, result.valid && result.gimbal_lock, result.angle_x == 19'd0)
  `RME_ASSERT_IMPLY(a_y_half_plane, clk, rst, result.valid, result.angle_y <= 19'd114251 || result.angle_y >= 19'd297524)
  `RME_ASSERT_NEXT(a_threshold_write, clk, rst, cfg_wr_en, gimbal_threshold == $past(cfg_wr_data))

endmodule

@@ design/rme_front.sv @@
// ----------------------------------------------------------------------------
// rme front
// accepts a matrix word, saturates the sine of y and squares it
// ----------------------------------------------------------------------------
module rme_front (
  input  logic              clk,
  input  logic              rst,
  rme_item_if.sink          item,
  output logic              word_valid,
  input  logic              word_ready,
  output rme_pkg::word_t    word
);

  logic               take;
  logic signed [17:0] s_sat;
  logic signed [35:0] sq_full;

  assign item.ready = !word_valid || word_ready;
  assign take = item.valid && item.ready;

  always_comb begin
    if (item.r0c2 > 18'sd65536) begin
      s_sat = 18'sd65536;
    end else if (item.r0c2 < -18'sd65536) begin
      s_sat = -18'sd65536;
    end else begin
      s_sat = item.r0c2;
    end
    sq_full = s_sat * s_sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (item.ready) begin
      word_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      word.side.r0c0 <= item.r0c0;
      word.side.r0c1 <= item.r0c1;
      word.side.r1c0 <= item.r1c0;
      word.side.r1c1 <= item.r1c1;
      word.side.r1c2 <= item.r1c2;
      word.side.r2c2 <= item.r2c2;
      word.side.s    <= s_sat;
      word.side.sel  <= item.axis_sel;
      word.sq        <= sq_full[32:0];
    end
  end

endmodule

@@ design/rme_queue.sv @@
// ----------------------------------------------------------------------------
// rme queue
// two-entry word queue between front and back
// ----------------------------------------------------------------------------
module rme_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  rme_pkg::word_t push_word,
  output logic           pop_valid,
  input  logic           pop_ready,
  output rme_pkg::word_t pop_word
);

  rme_pkg::word_t slot [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;
  logic           pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_word   = slot[rd_ptr];
  assign push = push_valid && push_ready;
  assign pop  = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_word;
    end
  end

endmodule

@@ design/rme_cordic.sv @@
// ----------------------------------------------------------------------------
// rme cordic
// pipelined vectoring cordic, one iteration a stage, angle wrapped to [0, 2pi)
// ----------------------------------------------------------------------------
module rme_cordic #(
  parameter int CORDIC_STEPS = 16,
  parameter int FRAC_BITS    = 16
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [19:0] y_in,
  input  logic signed [19:0] x_in,
  output logic [18:0]        angle
);

  localparam int N  = (CORDIC_STEPS < rme_pkg::TAB_LEN) ? CORDIC_STEPS : rme_pkg::TAB_LEN;
  localparam int ZW = FRAC_BITS + 4;
  localparam int XW = 30;
  localparam int TSH = 30 - FRAC_BITS;
  localparam logic signed [ZW-1:0] HP = ZW'(rme_pkg::HALF_PI_Q30 >> TSH);

  logic signed [XW-1:0] xa [N+1];
  logic signed [XW-1:0] ya [N+1];
  logic signed [ZW-1:0] za [N+1];
  logic                 zr [N+1];
  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [31:0]   q;
  logic signed [31:0]   qw;

  assign xs = $signed({{(XW-28){x_in[19]}}, x_in, 8'b0});
  assign ys = $signed({{(XW-28){y_in[19]}}, y_in, 8'b0});

  always_ff @(posedge clk) begin
    if (en) begin
      zr[0] <= (x_in == 20'sd0) && (y_in == 20'sd0);
      if (xs < 0) begin
        if (ys >= 0) begin
          xa[0] <= ys;
          ya[0] <= -xs;
          za[0] <= HP;
        end else begin
          xa[0] <= -ys;
          ya[0] <= xs;
          za[0] <= -HP;
        end
      end else begin
        xa[0] <= xs;
        ya[0] <= ys;
        za[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    localparam logic signed [ZW-1:0] STEP = ZW'(rme_pkg::ATAN_Q30[i] >> TSH);
    always_ff @(posedge clk) begin
      if (en) begin
        zr[i+1] <= zr[i];
        if (ya[i] >= 0) begin
          xa[i+1] <= xa[i] + (ya[i] >>> i);
          ya[i+1] <= ya[i] - (xa[i] >>> i);
          za[i+1] <= za[i] + STEP;
        end else begin
          xa[i+1] <= xa[i] - (ya[i] >>> i);
          ya[i+1] <= ya[i] + (xa[i] >>> i);
          za[i+1] <= za[i] - STEP;
        end
      end
    end
  end

  if (FRAC_BITS > 16) begin : g_round
    localparam int SH = FRAC_BITS - 16;
    localparam logic signed [ZW-1:0] HALF = ZW'(1) << (SH - 1);
    logic signed [ZW-1:0] zsum;
    logic signed [ZW-1:0] zsh;
    assign zsum = za[N] + HALF;
    assign zsh  = zsum >>> SH;
    assign q    = $signed({{(32-ZW){zsh[ZW-1]}}, zsh});
  end else begin : g_widen
    localparam int SH = 16 - FRAC_BITS;
    logic signed [31:0] zext;
    assign zext = $signed({{(32-ZW){za[N][ZW-1]}}, za[N]});
    assign q    = zext <<< SH;
  end

  assign qw = (q < 0) ? q + rme_pkg::TWO_PI_Q16 : q;

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= zr[N] ? 19'd0 : qw[18:0];
    end
  end

endmodule

@@ design/rme_back.sv @@
// ----------------------------------------------------------------------------
// rme back
// cosine square root, lock decision, three cordics and degree conversion
// ----------------------------------------------------------------------------
module rme_back #(
  parameter int CORDIC_STEPS = 16,
  parameter int FRAC_BITS    = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic [15:0]    threshold,
  input  logic           word_valid,
  output logic           word_ready,
  input  rme_pkg::word_t word,
  rme_result_if.source   result
);

  localparam int N  = (CORDIC_STEPS < rme_pkg::TAB_LEN) ? CORDIC_STEPS : rme_pkg::TAB_LEN;
  localparam int SQ = rme_pkg::SQRT_STAGES;
  localparam int CL = N + 2;
  localparam int L  = SQ + CL + 2;

  logic [L-1:0]          vpipe;
  logic                  en;
  logic [33:0]           sv [SQ+1];
  logic [33:0]           sr [SQ+1];
  rme_pkg::side_t        sd [SQ+1];
  logic [16:0]           c;
  logic                  lock;
  rme_pkg::side_t        sf;
  logic signed [19:0]    xy, xx, zy, zx, yy, yx;
  logic                  lk_d [CL];
  logic [1:0]            sel_d [CL];
  logic [18:0]           ax, ay, az;
  logic [18:0]           chosen;
  logic [18:0]           pax, pay, paz;
  logic                  plock;
  logic [48:0]           prod;

  assign en = !vpipe[L-1] || result.ready;
  assign word_ready = en;
  assign result.valid = vpipe[L-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else if (en) begin
      vpipe <= {vpipe[L-2:0], word_valid};
    end
  end

  // digit-by-digit square root of 2^32 - s*s
  assign sv[0] = 34'h1_0000_0000 - {1'b0, word.sq};
  assign sr[0] = '0;
  assign sd[0] = word.side;

  for (genvar k = 0; k < SQ; k++) begin : g_sqrt
    localparam logic [33:0] BIT = 34'd1 << (32 - 2 * k);
    logic [33:0] trial;
    assign trial = sr[k] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        sd[k+1] <= sd[k];
        if (sv[k] >= trial) begin
          sv[k+1] <= sv[k] - trial;
          sr[k+1] <= (sr[k] >> 1) + BIT;
        end else begin
          sv[k+1] <= sv[k];
          sr[k+1] <= sr[k] >> 1;
        end
      end
    end
  end

  assign c    = sr[SQ][16:0];
  assign lock = c < {1'b0, threshold};
  assign sf   = sd[SQ];

  always_comb begin
    yy = $signed({{2{sf.s[17]}}, sf.s});
    yx = $signed({3'b000, c});
    if (lock) begin
      xy = '0;
      xx = '0;
      zy = $signed({{2{sf.r1c0[17]}}, sf.r1c0});
      zx = $signed({{2{sf.r1c1[17]}}, sf.r1c1});
    end else begin
      xy = -$signed({{2{sf.r1c2[17]}}, sf.r1c2});
      xx = $signed({{2{sf.r2c2[17]}}, sf.r2c2});
      zy = -$signed({{2{sf.r0c1[17]}}, sf.r0c1});
      zx = $signed({{2{sf.r0c0[17]}}, sf.r0c0});
    end
  end

  rme_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS)) u_cordic_x (
    .clk(clk), .en(en), .y_in(xy), .x_in(xx), .angle(ax)
  );
  rme_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS)) u_cordic_y (
    .clk(clk), .en(en), .y_in(yy), .x_in(yx), .angle(ay)
  );
  rme_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .FRAC_BITS(FRAC_BITS)) u_cordic_z (
    .clk(clk), .en(en), .y_in(zy), .x_in(zx), .angle(az)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      lk_d[0]  <= lock;
      sel_d[0] <= sf.sel;
      for (int i = 1; i < CL; i++) begin
        lk_d[i]  <= lk_d[i-1];
        sel_d[i] <= sel_d[i-1];
      end
    end
  end

  always_comb begin
    case (sel_d[CL-1])
      rme_pkg::AXIS_X: chosen = ax;
      rme_pkg::AXIS_Y: chosen = ay;
      rme_pkg::AXIS_Z: chosen = az;
      default:         chosen = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pax   <= ax;
      pay   <= ay;
      paz   <= az;
      plock <= lk_d[CL-1];
      prod  <= chosen * rme_pkg::DEG_PER_RAD_Q24;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.angle_x          <= pax;
      result.angle_y          <= pay;
      result.angle_z          <= paz;
      result.gimbal_lock      <= plock;
      result.selected_degrees <= prod[48:32];
    end
  end

endmodule
